FILE: design/harris_corner_response_top_macros.svh
// ---------------------------------------------------------------------------
// Harris corner response: assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef HARRIS_CORNER_RESPONSE_TOP_MACROS_SVH
`define HARRIS_CORNER_RESPONSE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define HCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define HCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCR_ASSERT(lbl, prop, msg)
`define HCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/hcr_pkg.sv
// ---------------------------------------------------------------------------
// Harris corner response: shared package
// Controller states, command and status bundles, register indexes and the
// Gaussian kernel table.
// ---------------------------------------------------------------------------
`default_nettype none

package hcr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_PIX_FLUSH,
    ST_GRAD_WR,
    ST_WIN,
    ST_WIN_FLUSH,
    ST_MUL_INIT,
    ST_MUL,
    ST_THR,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } hcr_state_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [15:0] THRESH_RESET = 16'd2000;
  localparam int          MIN_DIM      = 7;

  localparam int PIX_TAPS  = 8;
  localparam int WIN_SIZE  = 5;
  localparam int DIV_BITS  = 15;
  localparam int ROW_W     = 13;
  localparam int POS_W     = 15;
  localparam int WIN_FLUSH = 2;

  // Normalized 5x5 sigma-1 weights with 32 fractional bits, indexed by class
  // of squared distance 0, 1, 2, 4, 5, 8.
  localparam logic [31:0] GAUSS_Q32 [0:5] = '{
    32'd696226318, 32'd422282608, 32'd256127349,
    32'd94223986,  32'd57149736,  32'd12751830
  };

  typedef struct packed {
    logic       capture;
    logic       pix_rd;
    logic [2:0] tap;
    logic       grad_wr;
    logic       win_rd;
    logic [2:0] win_r;
    logic [2:0] win_c;
    logic       mul_init;
    logic       mul_step;
    logic       thr;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } hcr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } hcr_stat_t;

  // Distance class of a window tap given its row and column within 0..4.
  function automatic logic [2:0] weight_class(logic [2:0] r, logic [2:0] c);
    logic [1:0] ar;
    logic [1:0] ac;
    logic [2:0] cls;
    ar = (r >= 3'd2) ? 2'(r - 3'd2) : 2'(3'd2 - r);
    ac = (c >= 3'd2) ? 2'(c - 3'd2) : 2'(3'd2 - c);
    case ({ar, ac}) inside
      4'b0000:          cls = 3'd0;
      4'b0001, 4'b0100: cls = 3'd1;
      4'b0101:          cls = 3'd2;
      4'b0010, 4'b1000: cls = 3'd3;
      4'b0110, 4'b1001: cls = 3'd4;
      default:          cls = 3'd5;
    endcase
    return cls;
  endfunction

  // Kernel weight rounded half up to frac fractional bits.
  function automatic logic [31:0] gauss_weight(logic [2:0] cls, int frac);
    logic [63:0] q;
    if (cls > 3'd5) q = 64'(GAUSS_Q32[5]);
    else            q = 64'(GAUSS_Q32[cls]);
    q = (q + (64'd1 << (31 - frac))) >> (32 - frac);
    return q[31:0];
  endfunction

  function automatic logic [1:0] add_mod3(logic [1:0] a, logic [1:0] b);
    logic [2:0] s;
    s = 3'(a) + 3'(b);
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

  function automatic logic [2:0] add_mod5(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = 4'(a) + 4'(b);
    if (s >= 4'd5) s = s - 4'd5;
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/harris_corner_response_top.sv
// ---------------------------------------------------------------------------
// Harris corner response: top level
// Streams grey pixels in raster order and returns one corner result per item.
// ---------------------------------------------------------------------------
// Input channel: in_tdata carries the pixel, in_tuser marks a drain item.
// Send the frame in raster order, then pad items to flush the tail.
// Each accepted item returns exactly one result on the out_ channel, for the
// position three rows plus three pixels behind; results before the frame
// start carry out_tuser low and zero fields.
// Configuration: cfg_index selects width, height or threshold; cfg_ready is
// high only while the block is idle and no pixel is offered. Width and height
// writes restart the frame at position 0.
// Pacing: one item at a time; the next item is accepted only once the last has
// passed the 8 pixel reads and 25 window reads on line memories with one read
// port each, the bit-serial determinant multiply and the 15-step divider.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and its result is held back until that register is free.
// Reset (rst_n low, synchronous) restores default registers and position 0.
// ---------------------------------------------------------------------------
`default_nettype none
`include "harris_corner_response_top_macros.svh"

module harris_corner_response_top #(
  parameter int MAX_WIDTH        = 1024,
  parameter int KERNEL_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] pixel
  input  wire         in_tuser,   // [0] pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [11:0] row, [21:12] column,
                                  // [36:22] response, [37] is_corner
  output logic        out_tuser,  // [0] valid_res
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import hcr_pkg::*;

  hcr_cmd_t  cmd;
  hcr_stat_t stat;

  // Register writes only land while no item is in flight.
  assign cfg_ready = in_tready && !in_tvalid;

  hcr_ctrl #(
    .MUL_STEPS (KERNEL_FRAC_BITS + 18)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  hcr_datapath #(
    .MAX_WIDTH        (MAX_WIDTH),
    .KERNEL_FRAC_BITS (KERNEL_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_pixel   (in_tdata),
    .in_pad     (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `HCR_ASSERT(a_one_item_at_a_time, in_tvalid && in_tready |=> !in_tready, "item accepted while busy")
  `HCR_ASSERT(a_corner_has_position, out_tvalid && out_tdata[37] |-> out_tuser, "corner without position")
  `HCR_ASSERT(a_response_needs_corner, out_tvalid && (out_tdata[36:22] != 15'd0) |-> out_tdata[37], "response without corner")
  `HCR_ASSERT_ALWAYS(a_reset_clears_output, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

`default_nettype wire

FILE: design/hcr_ctrl.sv
// ---------------------------------------------------------------------------
// Harris corner response: controller
// Sequences one item through pixel reads, gradient write, window sums,
// determinant, threshold test, quotient and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module hcr_ctrl #(
  parameter int MUL_STEPS = 34
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  output hcr_pkg::hcr_cmd_t  cmd,
  input  hcr_pkg::hcr_stat_t stat
);
  import hcr_pkg::*;

  localparam int CNT_MAX = (MUL_STEPS > DIV_BITS) ? MUL_STEPS : DIV_BITS;
  localparam int CNTW    = $clog2(CNT_MAX + 1);

  hcr_state_t      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [2:0]      wr_r, wr_nxt;
  logic [2:0]      wc_r, wc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      wr_r    <= '0;
      wc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wr_r    <= wr_nxt;
      wc_r    <= wc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wr_nxt    = wr_r;
    wc_nxt    = wc_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_PIX;
        end
      end
      ST_PIX: begin
        cmd.pix_rd = 1'b1;
        cmd.tap    = cnt_r[2:0];
        if (cnt_r == CNTW'(PIX_TAPS - 1)) state_nxt = ST_PIX_FLUSH;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_PIX_FLUSH: state_nxt = ST_GRAD_WR;
      ST_GRAD_WR: begin
        cmd.grad_wr = 1'b1;
        wr_nxt      = '0;
        wc_nxt      = '0;
        state_nxt   = ST_WIN;
      end
      ST_WIN: begin
        cmd.win_rd = 1'b1;
        cmd.win_r  = wr_r;
        cmd.win_c  = wc_r;
        if (wc_r == 3'(WIN_SIZE - 1)) begin
          wc_nxt = '0;
          if (wr_r == 3'(WIN_SIZE - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_WIN_FLUSH;
          end else begin
            wr_nxt = wr_r + 3'd1;
          end
        end else begin
          wc_nxt = wc_r + 3'd1;
        end
      end
      ST_WIN_FLUSH: begin
        if (cnt_r == CNTW'(WIN_FLUSH - 1)) state_nxt = ST_MUL_INIT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_MUL_INIT: begin
        cmd.mul_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CNTW'(MUL_STEPS - 1)) state_nxt = ST_THR;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNTW'(DIV_BITS - 1)) state_nxt = ST_DONE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/hcr_datapath.sv
// ---------------------------------------------------------------------------
// Harris corner response: datapath
// Position counters, pixel and gradient line memories, gradient and window
// accumulators, serial multiplier, restoring divider and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hcr_datapath #(
  parameter int MAX_WIDTH        = 1024,
  parameter int KERNEL_FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  hcr_pkg::hcr_cmd_t   cmd,
  output hcr_pkg::hcr_stat_t  stat,
  input  wire  [7:0]          in_pixel,
  input  wire                 in_pad,
  input  wire                 cfg_valid,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [39:0]         out_tdata,
  output logic                out_tuser
);
  import hcr_pkg::*;

  localparam int F   = KERNEL_FRAC_BITS;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PA  = $clog2(3 * MAX_WIDTH);
  localparam int GA  = $clog2(5 * MAX_WIDTH);
  localparam int SW  = F + 18;
  localparam int TW  = SW + 1;
  localparam int TPW = TW + 16;
  localparam int DW  = 2 * SW + 1;
  localparam int PW  = POS_W;

  localparam logic [1:0] SGN_ZERO = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
    logic [1:0] sx;
    logic [1:0] sy;
  } pix_tap_t;

  function automatic pix_tap_t pix_tap(logic [2:0] t);
    pix_tap_t p;
    case (t)
      3'd0:    p = '{2'd0, 2'd0, SGN_POS,  SGN_POS};
      3'd1:    p = '{2'd0, 2'd1, SGN_ZERO, SGN_POS};
      3'd2:    p = '{2'd0, 2'd2, SGN_NEG,  SGN_POS};
      3'd3:    p = '{2'd1, 2'd0, SGN_POS,  SGN_ZERO};
      3'd4:    p = '{2'd1, 2'd2, SGN_NEG,  SGN_ZERO};
      3'd5:    p = '{2'd2, 2'd0, SGN_POS,  SGN_NEG};
      3'd6:    p = '{2'd2, 2'd1, SGN_ZERO, SGN_NEG};
      default: p = '{2'd2, 2'd2, SGN_NEG,  SGN_NEG};
    endcase
    return p;
  endfunction

  function automatic logic [7:0] clamp8(logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0)        r = 8'd0;
    else if (v > 255) r = 8'd255;
    else              r = v[7:0];
    return r;
  endfunction

  // Configuration and position.
  logic [10:0]      wcfg_r;
  logic [11:0]      hcfg_r;
  logic [15:0]      thr_r;
  logic [ROW_W-1:0] ir_r;
  logic [CW-1:0]    ic_r;
  logic [1:0]       m3_r;
  logic [2:0]       m5_r;

  // Item context latched at capture.
  logic [CW-1:0] gc_r;
  logic [1:0]    g3_r;
  logic [2:0]    g5_r;
  logic          gr_ok_r;
  logic          grad_in_r;
  logic [11:0]   orow_r;
  logic [CW-1:0] ocol_r;
  logic [2:0]    o5_r;
  logic          out_ok_r;
  logic          win_in_r;

  // Memories.
  logic [7:0]  pmem [0:3*MAX_WIDTH-1];
  logic [15:0] gmem [0:5*MAX_WIDTH-1];
  logic [7:0]  pdat_r;
  logic [15:0] gdat_r;
  logic [PA-1:0] pwaddr, praddr;
  logic [GA-1:0] gwaddr, graddr;

  // Arithmetic.
  logic                 pv_r;
  logic [2:0]           ptap_r;
  logic signed [10:0]   sx_r, sy_r;
  logic                 wv1_r, wv2_r;
  logic [2:0]           wc1_r, wc2_r;
  logic [15:0]          pxx_r, pyy_r, pxy_r;
  logic [SW-1:0]        sxx_r, syy_r, sxy_r;
  logic [TW-1:0]        trace_r;
  logic [DW-1:0]        mca_r, mcb_r, pa_r, pb_r;
  logic [SW-1:0]        mpa_r, mpb_r;
  logic [DW-1:0]        det_r;
  logic [TPW-1:0]       thrp_r;
  logic [DW-1:0]        rem_r, t_r;
  logic [DIV_BITS-1:0]  q_r;
  logic                 corner_r;

  // Output register.
  logic                out_valid_r;
  logic                o_valid_r;
  logic [11:0]         o_row_r;
  logic [9:0]          o_col_r;
  logic [DIV_BITS-1:0] o_resp_r;
  logic                o_corner_r;

  logic [31:0]          w32;
  logic signed [PW-1:0] w_s, h_s, ir_s, ic_s, icn_s, gr_s, gc_s, or_s, oc_s;
  logic [7:0]           pix_in;
  pix_tap_t             rd_tap, acc_tap;
  logic signed [PW-1:0] pcol_s, gcol_s;
  logic signed [10:0]   pext;
  logic [F-1:0]         kw;
  logic [31:0]          oc32;

  always_comb begin
    w32 = 32'(wcfg_r);
    if (w32 < 32'(MIN_DIM))   w32 = 32'(MIN_DIM);
    if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    w_s = signed'(PW'(w32));
    h_s = (hcfg_r < 12'(MIN_DIM)) ? PW'(MIN_DIM) : signed'(PW'(hcfg_r));
    ir_s = signed'(PW'(ir_r));
    ic_s = signed'(PW'(ic_r));
    if (ic_s >= w_s) ic_s = '0;
    icn_s = ic_s + PW'(1);
    if (ic_s >= 1) begin
      gr_s = ir_s - PW'(1);
      gc_s = ic_s - PW'(1);
    end else begin
      gr_s = ir_s - PW'(2);
      gc_s = w_s - PW'(1);
    end
    if (ic_s >= 3) begin
      or_s = ir_s - PW'(3);
      oc_s = ic_s - PW'(3);
    end else begin
      or_s = ir_s - PW'(4);
      oc_s = ic_s + w_s - PW'(3);
    end
    pix_in = (in_pad || ir_s >= h_s) ? 8'd0 : in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcfg_r <= WIDTH_RESET;
      hcfg_r <= HEIGHT_RESET;
      thr_r  <= THRESH_RESET;
      ir_r   <= '0;
      ic_r   <= '0;
      m3_r   <= '0;
      m5_r   <= '0;
    end else if (cmd.capture) begin
      if (ir_s >= h_s + 3 && ic_s >= 2) begin
        ir_r <= '0;
        ic_r <= '0;
        m3_r <= '0;
        m5_r <= '0;
      end else if (icn_s >= w_s) begin
        ic_r <= '0;
        ir_r <= ir_r + 1'b1;
        m3_r <= add_mod3(m3_r, 2'd1);
        m5_r <= add_mod5(m5_r, 3'd1);
      end else begin
        ic_r <= icn_s[CW-1:0];
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH: begin
          wcfg_r <= cfg_data[10:0];
          ir_r <= '0;
          ic_r <= '0;
          m3_r <= '0;
          m5_r <= '0;
        end
        REG_HEIGHT: begin
          hcfg_r <= cfg_data[11:0];
          ir_r <= '0;
          ic_r <= '0;
          m3_r <= '0;
          m5_r <= '0;
        end
        REG_THRESH: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gc_r      <= gc_s[CW-1:0];
      g3_r      <= (ic_s >= 1) ? add_mod3(m3_r, 2'd2) : add_mod3(m3_r, 2'd1);
      g5_r      <= (ic_s >= 1) ? add_mod5(m5_r, 3'd4) : add_mod5(m5_r, 3'd3);
      gr_ok_r   <= gr_s >= 0 && gr_s < h_s;
      grad_in_r <= gr_s >= 1 && gr_s + 2 <= h_s && gc_s >= 1 && gc_s + 2 <= w_s;
      orow_r    <= or_s[11:0];
      ocol_r    <= oc_s[CW-1:0];
      o5_r      <= (ic_s >= 3) ? add_mod5(m5_r, 3'd2) : add_mod5(m5_r, 3'd1);
      out_ok_r  <= or_s >= 0 && or_s < h_s;
      win_in_r  <= or_s >= 2 && or_s + 3 <= h_s && oc_s >= 2 && oc_s + 3 <= w_s;
    end
  end

  // Pixel line memory: written at capture, read once per gradient tap.
  always_comb begin
    rd_tap = pix_tap(cmd.tap);
    pwaddr = PA'(m3_r) * PA'(MAX_WIDTH) + PA'(ic_s[CW-1:0]);
    pcol_s = grad_in_r ? signed'(PW'(gc_r)) + signed'(PW'(rd_tap.dc)) - PW'(1) : '0;
    praddr = PA'(add_mod3(add_mod3(g3_r, rd_tap.dr), 2'd2)) * PA'(MAX_WIDTH)
           + PA'(pcol_s[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) pmem[pwaddr] <= pix_in;
  end

  always_ff @(posedge clk) begin
    pdat_r <= pmem[praddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= cmd.pix_rd;
    ptap_r <= cmd.tap;
  end

  always_comb begin
    acc_tap = pix_tap(ptap_r);
    pext    = signed'({3'b000, pdat_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r <= '0;
      sy_r <= '0;
    end else if (pv_r) begin
      case (acc_tap.sx)
        SGN_POS: sx_r <= sx_r + pext;
        SGN_NEG: sx_r <= sx_r - pext;
        default: ;
      endcase
      case (acc_tap.sy)
        SGN_POS: sy_r <= sy_r + pext;
        SGN_NEG: sy_r <= sy_r - pext;
        default: ;
      endcase
    end
  end

  // Gradient line memory: at most one write per item, then the 5x5 window reads.
  always_comb begin
    gwaddr = GA'(g5_r) * GA'(MAX_WIDTH) + GA'(gc_r);
    gcol_s = win_in_r ? signed'(PW'(ocol_r)) + signed'(PW'(cmd.win_c)) - PW'(2) : '0;
    graddr = GA'(add_mod5(add_mod5(o5_r, cmd.win_r), 3'd3)) * GA'(MAX_WIDTH)
           + GA'(gcol_s[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.grad_wr && gr_ok_r)
      gmem[gwaddr] <= grad_in_r ? {clamp8(sx_r), clamp8(sy_r)} : 16'd0;
  end

  always_ff @(posedge clk) begin
    gdat_r <= gmem[graddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv1_r <= 1'b0;
      wv2_r <= 1'b0;
    end else begin
      wv1_r <= cmd.win_rd;
      wv2_r <= wv1_r;
    end
    wc1_r <= weight_class(cmd.win_r, cmd.win_c);
    wc2_r <= wc1_r;
    pxx_r <= 16'(gdat_r[15:8]) * 16'(gdat_r[15:8]);
    pyy_r <= 16'(gdat_r[7:0]) * 16'(gdat_r[7:0]);
    pxy_r <= 16'(gdat_r[15:8]) * 16'(gdat_r[7:0]);
  end

  assign kw = F'(gauss_weight(wc2_r, F));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (wv2_r) begin
      sxx_r <= sxx_r + SW'(kw) * SW'(pxx_r);
      syy_r <= syy_r + SW'(kw) * SW'(pyy_r);
      sxy_r <= sxy_r + SW'(kw) * SW'(pxy_r);
    end
  end

  // Determinant by shift and add, then threshold and quotient.
  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      mca_r   <= DW'(sxx_r);
      mpa_r   <= syy_r;
      mcb_r   <= DW'(sxy_r);
      mpb_r   <= sxy_r;
      pa_r    <= '0;
      pb_r    <= '0;
      trace_r <= TW'(sxx_r) + TW'(syy_r);
    end else if (cmd.mul_step) begin
      if (mpa_r[0]) pa_r <= pa_r + mca_r;
      if (mpb_r[0]) pb_r <= pb_r + mcb_r;
      mca_r <= mca_r << 1;
      mcb_r <= mcb_r << 1;
      mpa_r <= mpa_r >> 1;
      mpb_r <= mpb_r >> 1;
    end
    if (cmd.thr) begin
      det_r  <= (pa_r >= pb_r) ? pa_r - pb_r : '0;
      thrp_r <= TPW'(thr_r) * TPW'(trace_r);
    end
    if (cmd.div_init) begin
      corner_r <= win_in_r && (trace_r != '0) && ((DW'(thrp_r) << F) < det_r);
      rem_r    <= det_r;
      t_r      <= DW'(trace_r) << (F + DIV_BITS - 1);
      q_r      <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= t_r) rem_r <= rem_r - t_r;
      q_r <= {q_r[DIV_BITS-2:0], rem_r >= t_r};
      t_r <= t_r >> 1;
    end
  end

  // Result register; holds until the receiver takes it.
  assign oc32 = 32'(ocol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      o_valid_r  <= out_ok_r;
      o_row_r    <= out_ok_r ? orow_r : 12'd0;
      o_col_r    <= out_ok_r ? oc32[9:0] : 10'd0;
      o_resp_r   <= (out_ok_r && corner_r) ? q_r : '0;
      o_corner_r <= out_ok_r && corner_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tuser     = o_valid_r;
  assign out_tdata     = {2'b00, o_corner_r, o_resp_r, o_col_r, o_row_r};

endmodule

`default_nettype wire

FILE: tb/sv/harris_corner_response_checker.sv
// ---------------------------------------------------------------------------
// Harris corner response checker
// Watches the pixel, result and register channels. It keeps its own copy of
// the line stores and frame position, predicts each corner result and
// compares it with the result transfers in order.
// ---------------------------------------------------------------------------
module harris_corner_response_checker #(
  parameter int MAX_WIDTH        = 1024,
  parameter int KERNEL_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import hcr_pkg::*;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] row;
    logic [9:0]  column;
    logic [14:0] response;
    logic        is_corner;
  } corner_result_t;

  corner_result_t expected_results[$];

  logic [7:0]  pix_mem  [0:2][0:MAX_WIDTH-1];
  logic [15:0] grad_mem [0:4][0:MAX_WIDTH-1];
  int width_reg, height_reg, thresh_reg;
  int row_pos, col_pos;

  function automatic logic [63:0] tap_weight(int d2);
    int idx;
    case (d2)
      0: idx = 0;
      1: idx = 1;
      2: idx = 2;
      4: idx = 3;
      5: idx = 4;
      default: idx = 5;
    endcase
    return (64'(GAUSS_Q32[idx]) + (64'd1 << (31 - KERNEL_FRAC_BITS)))
           >> (32 - KERNEL_FRAC_BITS);
  endfunction

  function automatic logic [15:0] gradient_at(int r, int c, int w, int h);
    int sx, sy, d;
    sx = 0;
    sy = 0;
    if (r < 1 || r + 2 > h || c < 1 || c + 2 > w) return 16'd0;
    for (d = -1; d <= 1; d++) begin
      sx += int'(pix_mem[(r + d) % 3][c - 1]) - int'(pix_mem[(r + d) % 3][c + 1]);
      sy += int'(pix_mem[(r - 1) % 3][c + d]) - int'(pix_mem[(r + 1) % 3][c + d]);
    end
    if (sx < 0) sx = 0;
    if (sx > 255) sx = 255;
    if (sy < 0) sy = 0;
    if (sy > 255) sy = 255;
    return {sx[7:0], sy[7:0]};
  endfunction

  task automatic predict_pixel(input logic [7:0] pix, input logic pad,
                               output corner_result_t res);
    int w, h, ir, ic, gr, gc, orow, ocol, pv, dr, dc, b;
    logic [15:0]  v;
    logic [63:0]  sxx, syy, sxy, trace, k, gx, gy, q, cand;
    logic [127:0] a, m, det, lim;
    w = width_reg < 7 ? 7 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < 7 ? 7 : height_reg;
    ir = row_pos;
    ic = col_pos;
    pv = (pad || ir >= h) ? 0 : int'(pix);
    if (ic >= w) ic = 0;
    pix_mem[ir % 3][ic] = pv[7:0];

    if (ic >= 1) begin
      gr = ir - 1;
      gc = ic - 1;
    end else begin
      gr = ir - 2;
      gc = w - 1;
    end
    if (gr >= 0 && gr < h) grad_mem[gr % 5][gc] = gradient_at(gr, gc, w, h);

    if (ic >= 3) begin
      orow = ir - 3;
      ocol = ic - 3;
    end else begin
      orow = ir - 4;
      ocol = ic + w - 3;
    end

    res = '0;
    if (orow >= 0 && orow < h) begin
      res.valid_res = 1'b1;
      res.row = orow[11:0];
      res.column = ocol[9:0];
      // Only positions with a full 5x5 window inside the frame get a response.
      if (orow >= 2 && orow + 3 <= h && ocol >= 2 && ocol + 3 <= w) begin
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (dr = -2; dr <= 2; dr++) begin
          for (dc = -2; dc <= 2; dc++) begin
            v = grad_mem[(orow + dr) % 5][ocol + dc];
            gx = 64'(v[15:8]);
            gy = 64'(v[7:0]);
            k = tap_weight(dr * dr + dc * dc);
            sxx += k * gx * gx;
            syy += k * gy * gy;
            sxy += k * gx * gy;
          end
        end
        trace = sxx + syy;
        if (trace != 0) begin
          a = {64'd0, sxx} * {64'd0, syy};
          m = {64'd0, sxy} * {64'd0, sxy};
          det = (a < m) ? 128'd0 : a - m;
          lim = {64'd0, 64'(thresh_reg) * trace} << KERNEL_FRAC_BITS;
          if (lim < det) begin
            q = 0;
            for (b = 14; b >= 0; b--) begin
              cand = q | (64'd1 << b);
              if (!(det < ({64'd0, cand * trace} << KERNEL_FRAC_BITS))) q = cand;
            end
            res.response = q[14:0];
            res.is_corner = 1'b1;
          end
        end
      end
    end

    // The item that yields the last result of the drain starts a new frame.
    if (ir >= h + 3 && ic >= 2) begin
      row_pos = 0;
      col_pos = 0;
    end else begin
      ic++;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
      row_pos = ir;
      col_pos = ic;
    end
  endtask

  always @(posedge clk) begin
    corner_result_t exp_r, got_r;
    if (!rst_n) begin
      width_reg = int'(WIDTH_RESET);
      height_reg = int'(HEIGHT_RESET);
      thresh_reg = int'(THRESH_RESET);
      row_pos = 0;
      col_pos = 0;
      expected_results.delete();
      fail_count = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        for (int j = 0; j < 3; j++) pix_mem[j][i] = 8'd0;
        for (int j = 0; j < 5; j++) grad_mem[j][i] = 16'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_reg = int'(cfg_data[10:0]);
            row_pos = 0;
            col_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = int'(cfg_data[11:0]);
            row_pos = 0;
            col_pos = 0;
          end
          REG_THRESH: thresh_reg = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_pixel(in_tdata, in_tuser, exp_r);
        expected_results.push_back(exp_r);
      end
      if (out_tvalid && out_tready) begin
        got_r.valid_res = out_tuser;
        got_r.row = out_tdata[11:0];
        got_r.column = out_tdata[21:12];
        got_r.response = out_tdata[36:22];
        got_r.is_corner = out_tdata[37];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer: tuser=%0b tdata=%h",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.valid_res !== got_r.valid_res || exp_r.row !== got_r.row ||
              exp_r.column !== got_r.column || exp_r.response !== got_r.response ||
              exp_r.is_corner !== got_r.is_corner) begin
            $display("%0t: mismatch expected v=%0b r=%0d c=%0d resp=%0d corner=%0b",
                     $time, exp_r.valid_res, exp_r.row, exp_r.column,
                     exp_r.response, exp_r.is_corner);
            $display("%0t:          actual   v=%0b r=%0d c=%0d resp=%0d corner=%0b",
                     $time, got_r.valid_res, got_r.row, got_r.column,
                     got_r.response, got_r.is_corner);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/sv/tb_harris_corner_response_top.sv
// ---------------------------------------------------------------------------
// Harris corner response testbench
// Writes the geometry and threshold registers, streams directed and random
// frames with drain items under varying idle and stall patterns, and leaves
// prediction and comparison to the checker.
// ---------------------------------------------------------------------------
module tb_harris_corner_response_top;
  import hcr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_data = 16'd0;

  int fail_count, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int stall_hold = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  harris_corner_response_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  harris_corner_response_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls come in runs so that they land on every phase of the work.
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      stall_hold = $urandom_range(0, 60);
    end else begin
      stall_hold--;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 4000) begin
      $display("tb_harris_corner_response_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All tasks start and end at a falling edge. Ready is checked at the falling
  // edge, where it is settled until the next rising edge takes the transfer.
  task automatic push_pixel(input logic [7:0] pix, input logic pad);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 120);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= pad;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain_results();
    repeat (100) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A frame is a flat background with one bright or dark rectangle and some
  // noise, followed by the drain items. A nonzero stop_at breaks it off early.
  task automatic send_frame(input int w, input int h, input int stop_at,
                            input bit pause_mid);
    int n, r, c, total, bg, fg, r0, r1, c0, c1;
    logic [7:0] pix;
    total = (h + 3) * w + 3;
    bg = $urandom_range(1) ? 0 : 255;
    fg = $urandom_range(255);
    r0 = $urandom_range(0, h - 1);
    r1 = $urandom_range(r0, h - 1);
    c0 = $urandom_range(0, w - 1);
    c1 = $urandom_range(c0, w - 1);
    for (n = 0; n < total; n++) begin
      if (stop_at != 0 && n == stop_at) break;
      if (pause_mid && n == total / 2) drain_results();
      r = n / w;
      c = n % w;
      if (r < h) begin
        pix = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ? fg[7:0] : bg[7:0];
        if ($urandom_range(9) == 0) pix = $urandom_range(255);
        push_pixel(pix, $urandom_range(39) == 0);
      end else begin
        // Mostly pad items; now and then a plain pixel, which also drains.
        push_pixel($urandom_range(255), $urandom_range(3) != 0);
      end
    end
  endtask

  initial begin
    int w, h, frame_no, phase;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: smallest frame, extreme pixels, both threshold extremes.
    write_reg(REG_WIDTH, 16'd7);
    write_reg(REG_HEIGHT, 16'd7);
    write_reg(REG_THRESH, 16'd0);
    send_frame(7, 7, 0, 1'b0);
    write_reg(REG_THRESH, 16'hFFFF);
    send_frame(7, 7, 0, 1'b0);

    // Geometry beyond the allowed range is clamped; frames are cut short.
    write_reg(REG_WIDTH, 16'hFFFF);
    write_reg(REG_HEIGHT, 16'd0);
    write_reg(REG_THRESH, 16'd0);
    for (int i = 0; i < 20; i++) push_pixel($urandom_range(255), 1'b0);
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd4095);
    for (int i = 0; i < 20; i++) push_pixel($urandom_range(255), $urandom_range(1));
    write_reg(REG_WIDTH, 16'd1024);
    write_reg(REG_HEIGHT, 16'd7);
    for (int i = 0; i < 20; i++) push_pixel($urandom_range(255), 1'b0);

    frame_no = 0;
    while (items_sent < 700) begin
      phase = frame_no % 4;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      w = $urandom_range(7, 12);
      h = $urandom_range(7, 10);
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      case ($urandom_range(3))
        0: write_reg(REG_THRESH, 16'd0);
        1: write_reg(REG_THRESH, 16'($urandom_range(1, 3000)));
        2: write_reg(REG_THRESH, 16'($urandom_range(65535)));
        default: write_reg(REG_THRESH, 16'hFFFF);
      endcase
      if ($urandom_range(7) == 0)
        send_frame(w, h, $urandom_range(1, w * h), 1'b0);
      else
        send_frame(w, h, 0, frame_no == 3);
      frame_no++;
    end

    drain_results();
    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_harris_corner_response_top OK");
    end else begin
      $display("tb_harris_corner_response_top NOT OK");
    end
    $finish;
  end

endmodule
